FILE: src/msf_pkg.sv
// Package for the message slot FIFO: operation and status codes, the
// controller-to-datapath command and status types. No dependencies.
package msf_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_EMPTY    = 3'd1;
	localparam logic [2:0] STAT_FULL     = 3'd2;
	localparam logic [2:0] STAT_TOO_LONG = 3'd3;
	localparam logic [2:0] STAT_SMALL    = 3'd4;

	localparam int unsigned LEN_W   = 7;
	localparam int unsigned COUNT_W = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_LEN,
		ST_RD_BYTE
	} ctrl_state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_WRITE,
		CMD_FLUSH,
		CMD_NOP_RES,
		CMD_EMPTY,
		CMD_RD_START,
		CMD_RD_SMALL,
		CMD_RD_POP_ZERO,
		CMD_RD_POP,
		CMD_RD_BYTE
	} dp_cmd_t;

	typedef struct packed {
		logic held_zero;
		logic len_gt_cap;
		logic len_zero;
		logic byte_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: src/message_slot_fifo.sv
// Top level of the message slot FIFO: controller and datapath.
// Depends on msf_pkg, msf_ctrl and msf_datapath.
//
// Use: the input channel (in_valid, in_stall) takes one word per operation:
// a message byte to write, a read request or a flush. The output channel
// (out_valid, out_stall) returns result words from an output register.
// A write byte, flush, no-op or read on an empty queue gives one result
// in the cycle after acceptance, and a new word is taken every cycle unless
// the output stalls. A read of a stored message first registers the stored
// length from the length memory and checks it, then pops the slot and fetches
// the first byte from the byte memory, then streams the bytes one per cycle
// unless the output stalls; a rejected read gives a single result. No
// new word is taken until the last byte of a read has entered the output
// register. While the receiver stalls, the output word holds and in_stall
// rises once a further result would be needed.
// Reset empties the queue and discards a partly written message; slot
// memories keep their contents and need no clearing.
module message_slot_fifo import msf_pkg::*; #(
	parameter int unsigned SLOTS     = 16,
	parameter int unsigned MSG_BYTES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic [LEN_W-1:0]   read_capacity,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [7:0]         out_byte,
	output logic               last_result,
	output logic [LEN_W-1:0]   msg_length,
	output logic [COUNT_W-1:0] msg_count
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	msf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	msf_datapath #(
		.SLOTS     (SLOTS),
		.MSG_BYTES (MSG_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.read_capacity (read_capacity),
		.out_stall     (out_stall),
		.stat          (stat),
		.out_valid     (out_valid),
		.status        (status),
		.out_byte      (out_byte),
		.last_result   (last_result),
		.msg_length    (msg_length),
		.msg_count     (msg_count)
	);

endmodule

FILE: src/msf_ctrl.sv
// Controller state machine of the message slot FIFO.
// Depends on msf_pkg; drives commands into msf_datapath.
module msf_ctrl import msf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] op,
	input  dp_stat_t   stat,
	output logic       in_stall,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_nxt;
	logic        accept;

	assign accept = in_valid && stat.out_free && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_READ && !stat.held_zero) begin
					state_nxt = ST_RD_LEN;
				end
			end
			ST_RD_LEN: begin
				if (stat.out_free) begin
					if (stat.len_gt_cap || stat.len_zero) begin
						state_nxt = ST_IDLE;
					end else begin
						state_nxt = ST_RD_BYTE;
					end
				end
			end
			ST_RD_BYTE: begin
				if (stat.out_free && stat.byte_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = CMD_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = !stat.out_free;
				if (accept) begin
					unique case (op)
						OP_WRITE: cmd = CMD_WRITE;
						OP_READ:  cmd = stat.held_zero ? CMD_EMPTY : CMD_RD_START;
						OP_FLUSH: cmd = CMD_FLUSH;
						OP_NONE:  cmd = CMD_NOP_RES;
						default:  cmd = CMD_NOP_RES;
					endcase
				end
			end
			ST_RD_LEN: begin
				if (stat.out_free) begin
					priority if (stat.len_gt_cap) begin
						cmd = CMD_RD_SMALL;
					end else if (stat.len_zero) begin
						cmd = CMD_RD_POP_ZERO;
					end else begin
						cmd = CMD_RD_POP;
					end
				end
			end
			ST_RD_BYTE: begin
				if (stat.out_free) begin
					cmd = CMD_RD_BYTE;
				end
			end
			default: cmd = CMD_NONE;
		endcase
	end

endmodule

FILE: src/msf_datapath.sv
// Datapath of the message slot FIFO: slot byte and length memories, ring
// pointers, write assembly state and the output register. Depends on msf_pkg.
module msf_datapath import msf_pkg::*; #(
	parameter int unsigned SLOTS     = 16,
	parameter int unsigned MSG_BYTES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic [LEN_W-1:0]   read_capacity,
	input  logic               out_stall,
	output dp_stat_t           stat,
	output logic               out_valid,
	output logic [2:0]         status,
	output logic [7:0]         out_byte,
	output logic               last_result,
	output logic [LEN_W-1:0]   msg_length,
	output logic [COUNT_W-1:0] msg_count
);

	localparam int unsigned IW    = $clog2(SLOTS);
	localparam int unsigned OW    = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
	localparam int unsigned DEPTH = SLOTS * (2 ** OW);
	localparam logic [LEN_W-1:0]   MSG_LEN  = LEN_W'(MSG_BYTES);
	localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(SLOTS - 1);
	localparam logic [IW-1:0]      LAST_SLOT = IW'(SLOTS - 1);

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
		return (i == LAST_SLOT) ? '0 : i + IW'(1);
	endfunction

	logic [7:0]       byte_mem [DEPTH];
	logic [LEN_W-1:0] len_mem  [SLOTS];

	logic [IW-1:0]      head_q, tail_q, rd_slot_q;
	logic [COUNT_W-1:0] count_q;
	logic [LEN_W-1:0]   fill_q, lrd_q, cap_q, len_q;
	logic               ovf_q;
	logic [OW-1:0]      k_q;
	logic [7:0]         brd_q;

	logic               out_valid_q, last_q;
	logic [2:0]         status_q;
	logic [7:0]         byte_q;
	logic [LEN_W-1:0]   mlen_q;
	logic [COUNT_W-1:0] mcnt_q;

	logic [IW-1:0]      slot_w, slot_r;
	logic               fill_lt, wr_ovf, is_full, commit;
	logic [LEN_W-1:0]   wr_len, len_clamp, cap_clamp;
	logic               bwe, bre, res_load;
	logic [IW+OW-1:0]   bwaddr, braddr;
	logic [2:0]         res_status;
	logic [7:0]         res_byte;
	logic               res_last;
	logic [LEN_W-1:0]   res_len;
	logic [COUNT_W-1:0] res_cnt;

	assign slot_w    = nxt(tail_q);
	assign slot_r    = nxt(head_q);
	assign fill_lt   = fill_q < MSG_LEN;
	assign wr_len    = fill_lt ? fill_q + LEN_W'(1) : fill_q;
	assign wr_ovf    = ovf_q | ~fill_lt;
	assign is_full   = count_q == FULL_CNT;
	assign commit    = (cmd == CMD_WRITE) && last_byte && !wr_ovf && !is_full;
	assign len_clamp = (lrd_q > MSG_LEN) ? MSG_LEN : lrd_q;
	assign cap_clamp = (read_capacity > MSG_LEN) ? MSG_LEN : read_capacity;

	assign bwe    = (cmd == CMD_WRITE) && fill_lt;
	assign bwaddr = {slot_w, fill_q[OW-1:0]};
	assign bre    = (cmd == CMD_RD_POP) || (cmd == CMD_RD_BYTE);
	assign braddr = (cmd == CMD_RD_POP) ? {slot_r, OW'(0)} : {rd_slot_q, k_q + OW'(1)};

	assign stat.held_zero  = count_q == '0;
	assign stat.len_gt_cap = len_clamp > cap_q;
	assign stat.len_zero   = len_clamp == '0;
	assign stat.byte_last  = (LEN_W'(k_q) + LEN_W'(1)) == len_q;
	assign stat.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (bwe) begin
			byte_mem[bwaddr] <= data_byte;
		end
		if (bre) begin
			brd_q <= byte_mem[braddr];
		end
		if (commit) begin
			len_mem[slot_w] <= wr_len;
		end
		if (cmd == CMD_RD_START) begin
			lrd_q <= len_mem[slot_r];
		end
	end

	always_comb begin
		res_load   = 1'b0;
		res_status = STAT_OK;
		res_byte   = 8'd0;
		res_last   = 1'b1;
		res_len    = '0;
		res_cnt    = count_q;
		unique case (cmd)
			CMD_WRITE: begin
				res_load = 1'b1;
				res_len  = wr_len;
				priority if (wr_ovf) begin
					res_status = STAT_TOO_LONG;
				end else if (last_byte && is_full) begin
					res_status = STAT_FULL;
				end else if (last_byte) begin
					res_cnt = count_q + COUNT_W'(1);
				end
			end
			CMD_FLUSH: begin
				res_load = 1'b1;
				res_cnt  = '0;
			end
			CMD_NOP_RES: res_load = 1'b1;
			CMD_EMPTY: begin
				res_load   = 1'b1;
				res_status = STAT_EMPTY;
			end
			CMD_RD_SMALL: begin
				res_load   = 1'b1;
				res_status = STAT_SMALL;
				res_len    = len_clamp;
			end
			CMD_RD_POP_ZERO: begin
				res_load = 1'b1;
				res_cnt  = count_q - COUNT_W'(1);
			end
			CMD_RD_BYTE: begin
				res_load = 1'b1;
				res_byte = brd_q;
				res_last = stat.byte_last;
				res_len  = len_q;
			end
			CMD_NONE, CMD_RD_START, CMD_RD_POP: res_load = 1'b0;
			default: res_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd)
				CMD_WRITE: begin
					if (last_byte) begin
						fill_q <= '0;
						ovf_q  <= 1'b0;
						if (commit) begin
							tail_q  <= slot_w;
							count_q <= count_q + COUNT_W'(1);
						end
					end else begin
						fill_q <= wr_len;
						ovf_q  <= wr_ovf;
					end
				end
				CMD_FLUSH: begin
					head_q  <= '0;
					tail_q  <= '0;
					count_q <= '0;
					fill_q  <= '0;
					ovf_q   <= 1'b0;
				end
				CMD_RD_POP_ZERO, CMD_RD_POP: begin
					head_q  <= slot_r;
					count_q <= count_q - COUNT_W'(1);
				end
				default: begin
				end
			endcase
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_RD_START) begin
			cap_q <= cap_clamp;
		end
		if (cmd == CMD_RD_POP) begin
			rd_slot_q <= slot_r;
			len_q     <= len_clamp;
			k_q       <= '0;
		end else if (cmd == CMD_RD_BYTE) begin
			k_q <= k_q + OW'(1);
		end
		if (res_load) begin
			status_q <= res_status;
			byte_q   <= res_byte;
			last_q   <= res_last;
			mlen_q   <= res_len;
			mcnt_q   <= res_cnt;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_byte    = byte_q;
	assign last_result = last_q;
	assign msg_length  = mlen_q;
	assign msg_count   = mcnt_q;

endmodule

FILE: src/msf_checker.sv
// Port-level checker for the message slot FIFO and its bind to the top level.
// Depends on msf_pkg and message_slot_fifo.
module msf_checker import msf_pkg::*; #(
	parameter int unsigned SLOTS     = 16,
	parameter int unsigned MSG_BYTES = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         status,
	input logic [7:0]         out_byte,
	input logic               last_result,
	input logic [LEN_W-1:0]   msg_length,
	input logic [COUNT_W-1:0] msg_count
);

	localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(SLOTS - 1);
	localparam logic [LEN_W-1:0]   MSG_LEN  = LEN_W'(MSG_BYTES);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(status))
		else $error("Stalled output word changed.");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> msg_count <= FULL_CNT && msg_length <= MSG_LEN)
		else $error("Message count or length out of range.");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> last_result && out_byte == 8'd0)
		else $error("Error result is not a single word.");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> status == STAT_OK && msg_length != '0)
		else $error("Partial read word without a message.");

endmodule

bind message_slot_fifo msf_checker #(
	.SLOTS     (SLOTS),
	.MSG_BYTES (MSG_BYTES)
) u_msf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.out_byte    (out_byte),
	.last_result (last_result),
	.msg_length  (msg_length),
	.msg_count   (msg_count)
);
